[rtl/core/wead_pkg.sv]
// Shared types and constants of the window entropy anomaly detector.
// No dependencies; the files that use it refer to this package by scoped names.
package wead_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int FRAC_BITS    = 24;
    localparam int LOG_W        = $clog2(CNT_W) + FRAC_BITS;
    localparam int STEP_W       = $clog2(FRAC_BITS);
    localparam int PROD_W       = CNT_W + LOG_W;
    localparam int Q16_W        = 17;
    localparam int FEATURES     = 5;
    localparam int DIV_QB       = 20;
    localparam int DIV_BIT_W    = $clog2(DIV_QB);
    localparam int DIV_W        = PROD_W + DIV_QB - 1;
    localparam int DEF_W        = 19;
    localparam int DIV5_W       = 20;
    localparam int DIV5_SHIFT   = 22;
    localparam int SCORE_PROD_W = DEF_W + DIV5_W;

    localparam logic [Q16_W-1:0]  Q16_ONE        = 17'd65536;
    localparam logic [Q16_W-1:0]  THRESHOLD_INIT = 17'd32768;
    // floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for x < 2**22
    localparam logic [DIV5_W-1:0] DIV5_MUL       = 20'd838861;

    typedef enum logic [2:0] {
        FEAT_SRC_ADDR,
        FEAT_DST_ADDR,
        FEAT_SRC_PORT,
        FEAT_DST_PORT,
        FEAT_TUPLE
    } t_feature;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOGN,
        ST_TOT,
        ST_FEAT,
        ST_RDI,
        ST_KEYI,
        ST_SCAN,
        ST_RUN,
        ST_LOGC,
        ST_MULC,
        ST_NEXTI,
        ST_ULOG,
        ST_UWAIT,
        ST_DEN,
        ST_DIV,
        ST_ACC,
        ST_SCORE,
        ST_OUT
    } t_back_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       src;
        logic [31:0]       dst;
        logic [31:0]       ports;
    } t_store_wr;

    typedef struct packed {
        logic [CNT_W-1:0] flows;
        logic [CNT_W-1:0] attacks;
    } t_win_cmd;

endpackage

[rtl/core/wead_if.sv]
// Channel interfaces of the detector: flow records in, results out, threshold writes.
// Depends on nothing.
interface wead_flow_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic        attack_label;
    logic        addresses_present;
    logic        last_in_window;

    modport source(output valid, src_addr, dst_addr, src_port_in, dst_port_in,
                   attack_label, addresses_present, last_in_window, input ready);
    modport sink(input valid, src_addr, dst_addr, src_port_in, dst_port_in,
                 attack_label, addresses_present, last_in_window, output ready);
endinterface

interface wead_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] ent_src_addr;
    logic [16:0] ent_dst_addr;
    logic [16:0] ent_src_port;
    logic [16:0] ent_dst_port;
    logic [16:0] ent_tuple;
    logic [16:0] anomaly_score;
    logic        attack_predicted;
    logic        majority_attack;
    logic [10:0] valid_flows;

    modport source(output valid, ent_src_addr, ent_dst_addr, ent_src_port, ent_dst_port,
                   ent_tuple, anomaly_score, attack_predicted, majority_attack,
                   valid_flows, input ready);
    modport sink(input valid, ent_src_addr, ent_dst_addr, ent_src_port, ent_dst_port,
                 ent_tuple, anomaly_score, attack_predicted, majority_attack,
                 valid_flows, output ready);
endinterface

interface wead_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] score_threshold;

    modport source(output valid, score_threshold, input ready);
    modport sink(input valid, score_threshold, output ready);
endinterface

[rtl/core/wead_fifo.sv]
// Two-entry queue of window-end commands between front and back.
// Depends on wead_pkg.
module wead_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wead_pkg::t_win_cmd i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output wead_pkg::t_win_cmd o_data
);
    wead_pkg::t_win_cmd r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

[rtl/core/wead_log2.sv]
// Iterative log2 in Q.24: one squaring of the mantissa per cycle.
// Depends on wead_pkg.
module wead_log2 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wead_pkg::CNT_W-1:0]   i_x,
    output logic                         o_done,
    output logic [wead_pkg::LOG_W-1:0]   o_res
);
    localparam int K_W = wead_pkg::LOG_W - wead_pkg::FRAC_BITS;

    logic                           r_busy;
    logic                           r_done;
    logic [31:0]                    r_m;
    logic [wead_pkg::LOG_W-1:0]     r_res;
    logic [wead_pkg::STEP_W-1:0]    r_step;
    logic [K_W-1:0]                 msb;
    logic [63:0]                    sq;
    logic [32:0]                    m2;

    always_comb begin
        msb = '0;
        for (int b = 0; b < wead_pkg::CNT_W; b++) begin
            if (i_x[b]) begin
                msb = K_W'(b);
            end
        end
    end

    assign sq     = 64'(r_m) * 64'(r_m);
    assign m2     = sq[63:31];
    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= 32'(i_x) << (5'd31 - 5'(msb));
            r_res  <= {msb, wead_pkg::FRAC_BITS'(0)};
            r_step <= wead_pkg::STEP_W'(wead_pkg::FRAC_BITS - 1);
        end else if (r_busy) begin
            // mantissa squared reaching 2.0 yields a one bit
            if (m2[32]) begin
                r_m           <= m2[32:1];
                r_res[r_step] <= 1'b1;
            end else begin
                r_m <= m2[31:0];
            end
            r_step <= r_step - 1'b1;
        end
    end
endmodule

[rtl/core/wead_front.sv]
// Front end: accepts flow beats, writes kept flows to the store, counts labels
// and queues a window-end command. Depends on wead_pkg and wead_if.
module wead_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wead_flow_if.sink             i_flow,
    input  logic                  i_release,
    input  logic                  i_cmd_full,
    output logic                  o_cmd_push,
    output wead_pkg::t_win_cmd    o_cmd,
    output wead_pkg::t_store_wr   o_wr
);
    logic [wead_pkg::CNT_W-1:0] r_count, n_count;
    logic [wead_pkg::CNT_W-1:0] r_attack, n_attack;
    logic                       r_hold, n_hold;
    logic                       acc;
    logic                       keep;
    logic [wead_pkg::CNT_W-1:0] count_upd;
    logic [wead_pkg::CNT_W-1:0] attack_upd;

    assign i_flow.ready = !r_hold && !i_cmd_full;
    assign acc  = i_flow.valid && i_flow.ready;
    assign keep = acc && i_flow.addresses_present &&
                  (r_count < wead_pkg::CNT_W'(wead_pkg::WINDOW_DEPTH));

    assign count_upd  = keep ? r_count + 1'b1 : r_count;
    assign attack_upd = (keep && i_flow.attack_label) ? r_attack + 1'b1 : r_attack;

    assign o_wr.en    = keep;
    assign o_wr.addr  = r_count[wead_pkg::ADDR_W-1:0];
    assign o_wr.src   = i_flow.src_addr;
    assign o_wr.dst   = i_flow.dst_addr;
    assign o_wr.ports = {i_flow.src_port_in, i_flow.dst_port_in};

    assign o_cmd_push    = acc && i_flow.last_in_window;
    assign o_cmd.flows   = count_upd;
    assign o_cmd.attacks = attack_upd;

    always_comb begin
        n_count  = count_upd;
        n_attack = attack_upd;
        n_hold   = r_hold;
        if (i_release) begin
            n_hold = 1'b0;
        end
        // store stays frozen until the back end has read the whole window
        if (o_cmd_push) begin
            n_count  = '0;
            n_attack = '0;
            n_hold   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_attack <= '0;
            r_hold   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_attack <= n_attack;
            r_hold   <= n_hold;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |=> (r_count == '0 && r_hold))
        else $error("window end did not clear counters and freeze store");
    a_hold_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold && !i_release) |=> r_hold)
        else $error("hold dropped without release");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("command pushed into full queue");
`endif
endmodule

[rtl/core/wead_back.sv]
// Back end: flow store, distinct-value scan, entropy, score and result register.
// Depends on wead_pkg, wead_if and wead_log2.
module wead_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wead_pkg::t_store_wr   i_wr,
    input  logic                  i_cmd_valid,
    input  wead_pkg::t_win_cmd    i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_release,
    wead_cfg_if.sink              i_cfg,
    wead_result_if.source         o_result
);
    localparam int AW = wead_pkg::ADDR_W;
    localparam int CW = wead_pkg::CNT_W;
    localparam int LW = wead_pkg::LOG_W;
    localparam int PW = wead_pkg::PROD_W;
    localparam int DW = wead_pkg::DIV_W;
    localparam int QW = wead_pkg::Q16_W;

    logic [31:0] mem_src   [wead_pkg::WINDOW_DEPTH];
    logic [31:0] mem_dst   [wead_pkg::WINDOW_DEPTH];
    logic [31:0] mem_ports [wead_pkg::WINDOW_DEPTH];
    logic [31:0] r_rd_src, r_rd_dst, r_rd_ports;
    logic [AW-1:0] rd_addr;

    wead_pkg::t_back_state r_state, n_state;
    wead_pkg::t_feature    r_feat;

    logic [CW-1:0] r_n, r_attack, r_i, r_j, r_pj, r_cnt, r_distinct;
    logic          r_pend, r_dup, r_empty;
    logic [31:0]   r_ki_src, r_ki_dst, r_ki_ports;
    logic [LW-1:0] r_ln, r_lc, r_lu;
    logic [PW-1:0] r_total, r_s;
    logic [DW-1:0] r_rem, r_dsh;
    logic [wead_pkg::DIV_QB-1:0]    r_q;
    logic [wead_pkg::DIV_BIT_W-1:0] r_bit;
    logic [QW-1:0] r_ent [wead_pkg::FEATURES];
    logic [wead_pkg::DEF_W-1:0]        r_deficit;
    logic [wead_pkg::SCORE_PROD_W-1:0] r_sprod;
    logic [QW-1:0] r_thr;

    logic          r_o_valid;
    logic [QW-1:0] r_o_ent [wead_pkg::FEATURES];
    logic [QW-1:0] r_o_score;
    logic          r_o_pred, r_o_major;
    logic [CW-1:0] r_o_flows;

    logic          log_start, log_done;
    logic [CW-1:0] log_x;
    logic [LW-1:0] log_res;
    logic          match;
    logic          out_load;
    logic [QW-1:0] e_sat;
    logic [QW-1:0] score;

    wead_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_res   (log_res)
    );

    // flow store: written by the front, read here at one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_src[i_wr.addr]   <= i_wr.src;
            mem_dst[i_wr.addr]   <= i_wr.dst;
            mem_ports[i_wr.addr] <= i_wr.ports;
        end
        r_rd_src   <= mem_src[rd_addr];
        r_rd_dst   <= mem_dst[rd_addr];
        r_rd_ports <= mem_ports[rd_addr];
    end

    always_comb begin
        case (r_feat)
            wead_pkg::FEAT_SRC_ADDR: match = (r_rd_src == r_ki_src);
            wead_pkg::FEAT_DST_ADDR: match = (r_rd_dst == r_ki_dst);
            wead_pkg::FEAT_SRC_PORT: match = (r_rd_ports[31:16] == r_ki_ports[31:16]);
            wead_pkg::FEAT_DST_PORT: match = (r_rd_ports[15:0] == r_ki_ports[15:0]);
            wead_pkg::FEAT_TUPLE:    match = (r_rd_src == r_ki_src) &&
                                             (r_rd_dst == r_ki_dst) &&
                                             (r_rd_ports == r_ki_ports);
            default:                 match = 1'b0;
        endcase
    end

    assign e_sat = (r_q > wead_pkg::DIV_QB'(wead_pkg::Q16_ONE)) ? wead_pkg::Q16_ONE
                                                               : r_q[QW-1:0];
    assign score = r_sprod[wead_pkg::DIV5_SHIFT +: QW];

    always_comb begin
        n_state   = r_state;
        rd_addr   = r_j[AW-1:0];
        log_start = 1'b0;
        log_x     = r_n;
        o_cmd_pop = 1'b0;
        o_release = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            wead_pkg::ST_IDLE: begin
                log_x = i_cmd.flows;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.flows == '0) begin
                        n_state = wead_pkg::ST_OUT;
                    end else begin
                        log_start = 1'b1;
                        n_state   = wead_pkg::ST_LOGN;
                    end
                end
            end
            wead_pkg::ST_LOGN: begin
                if (log_done) begin
                    n_state = wead_pkg::ST_TOT;
                end
            end
            wead_pkg::ST_TOT:  n_state = wead_pkg::ST_FEAT;
            wead_pkg::ST_FEAT: n_state = wead_pkg::ST_RDI;
            wead_pkg::ST_RDI: begin
                rd_addr = r_i[AW-1:0];
                n_state = wead_pkg::ST_KEYI;
            end
            wead_pkg::ST_KEYI: n_state = wead_pkg::ST_SCAN;
            wead_pkg::ST_SCAN: begin
                if (r_j == r_n) begin
                    n_state = wead_pkg::ST_RUN;
                end
            end
            wead_pkg::ST_RUN: begin
                log_x = r_cnt;
                if (r_dup) begin
                    n_state = wead_pkg::ST_NEXTI;
                end else begin
                    log_start = 1'b1;
                    n_state   = wead_pkg::ST_LOGC;
                end
            end
            wead_pkg::ST_LOGC: begin
                if (log_done) begin
                    n_state = wead_pkg::ST_MULC;
                end
            end
            wead_pkg::ST_MULC: n_state = wead_pkg::ST_NEXTI;
            wead_pkg::ST_NEXTI: begin
                if (r_i + 1'b1 == r_n) begin
                    n_state = wead_pkg::ST_ULOG;
                end else begin
                    n_state = wead_pkg::ST_RDI;
                end
            end
            wead_pkg::ST_ULOG: begin
                log_x = r_distinct;
                if (r_distinct < CW'(2)) begin
                    n_state = wead_pkg::ST_ACC;
                end else begin
                    log_start = 1'b1;
                    n_state   = wead_pkg::ST_UWAIT;
                end
            end
            wead_pkg::ST_UWAIT: begin
                if (log_done) begin
                    n_state = wead_pkg::ST_DEN;
                end
            end
            wead_pkg::ST_DEN: n_state = wead_pkg::ST_DIV;
            wead_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = wead_pkg::ST_ACC;
                end
            end
            wead_pkg::ST_ACC: begin
                if (r_feat == wead_pkg::FEAT_TUPLE) begin
                    n_state = wead_pkg::ST_SCORE;
                end else begin
                    n_state = wead_pkg::ST_FEAT;
                end
            end
            wead_pkg::ST_SCORE: n_state = wead_pkg::ST_OUT;
            wead_pkg::ST_OUT: begin
                if (!r_o_valid || o_result.ready) begin
                    out_load  = 1'b1;
                    o_release = 1'b1;
                    n_state   = wead_pkg::ST_IDLE;
                end
            end
            default: n_state = wead_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wead_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wead_pkg::ST_IDLE: begin
                r_n       <= i_cmd.flows;
                r_attack  <= i_cmd.attacks;
                r_empty   <= (i_cmd.flows == '0);
                r_feat    <= wead_pkg::FEAT_SRC_ADDR;
                r_deficit <= '0;
            end
            wead_pkg::ST_LOGN: r_ln <= log_res;
            wead_pkg::ST_TOT:  r_total <= PW'(r_n) * PW'(r_ln);
            wead_pkg::ST_FEAT: begin
                r_i        <= '0;
                r_s        <= '0;
                r_distinct <= '0;
            end
            wead_pkg::ST_KEYI: begin
                r_ki_src   <= r_rd_src;
                r_ki_dst   <= r_rd_dst;
                r_ki_ports <= r_rd_ports;
                r_j        <= '0;
                r_pend     <= 1'b0;
                r_cnt      <= '0;
                r_dup      <= 1'b0;
            end
            wead_pkg::ST_SCAN: begin
                // data of the address issued last cycle is compared now
                if (r_pend && match) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_pj < r_i) begin
                        r_dup <= 1'b1;
                    end
                end
                r_pj   <= r_j;
                r_pend <= (r_j < r_n);
                if (r_j < r_n) begin
                    r_j <= r_j + 1'b1;
                end
            end
            wead_pkg::ST_RUN: begin
                if (!r_dup) begin
                    r_distinct <= r_distinct + 1'b1;
                end
            end
            wead_pkg::ST_LOGC: r_lc <= log_res;
            wead_pkg::ST_MULC: r_s <= r_s + PW'(r_cnt) * PW'(r_lc);
            wead_pkg::ST_NEXTI: r_i <= r_i + 1'b1;
            wead_pkg::ST_ULOG: r_q <= '0;
            wead_pkg::ST_UWAIT: r_lu <= log_res;
            wead_pkg::ST_DEN: begin
                r_rem <= DW'((r_total > r_s) ? r_total - r_s : PW'(0)) << 16;
                r_dsh <= DW'(PW'(r_n) * PW'(r_lu)) << (wead_pkg::DIV_QB - 1);
                r_q   <= '0;
                r_bit <= wead_pkg::DIV_BIT_W'(wead_pkg::DIV_QB - 1);
            end
            wead_pkg::ST_DIV: begin
                if (r_dsh <= r_rem) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[wead_pkg::DIV_QB-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[wead_pkg::DIV_QB-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - 1'b1;
            end
            wead_pkg::ST_ACC: begin
                r_ent[r_feat] <= e_sat;
                r_deficit     <= r_deficit + wead_pkg::DEF_W'(wead_pkg::Q16_ONE - e_sat);
                r_feat        <= wead_pkg::t_feature'(3'(r_feat) + 3'd1);
            end
            wead_pkg::ST_SCORE: begin
                r_sprod <= wead_pkg::SCORE_PROD_W'(r_deficit) *
                           wead_pkg::SCORE_PROD_W'(wead_pkg::DIV5_MUL);
            end
            default: ;
        endcase
    end

    // threshold register and result register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= wead_pkg::THRESHOLD_INIT;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.score_threshold;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int f = 0; f < wead_pkg::FEATURES; f++) begin
                r_o_ent[f] <= r_empty ? '0 : r_ent[f];
            end
            r_o_score <= r_empty ? '0 : score;
            r_o_pred  <= !r_empty && (score > r_thr);
            r_o_major <= !r_empty && (r_attack > (r_n >> 1));
            r_o_flows <= r_n;
        end
    end

    assign o_result.valid            = r_o_valid;
    assign o_result.ent_src_addr     = r_o_ent[wead_pkg::FEAT_SRC_ADDR];
    assign o_result.ent_dst_addr     = r_o_ent[wead_pkg::FEAT_DST_ADDR];
    assign o_result.ent_src_port     = r_o_ent[wead_pkg::FEAT_SRC_PORT];
    assign o_result.ent_dst_port     = r_o_ent[wead_pkg::FEAT_DST_PORT];
    assign o_result.ent_tuple        = r_o_ent[wead_pkg::FEAT_TUPLE];
    assign o_result.anomaly_score    = r_o_score;
    assign o_result.attack_predicted = r_o_pred;
    assign o_result.majority_attack  = r_o_major;
    assign o_result.valid_flows      = r_o_flows;

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == wead_pkg::ST_IDLE))
        else $error("command taken while a window is in progress");
    a_release_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_release |=> r_o_valid)
        else $error("store released without a result");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wead_pkg::ST_SCAN) |-> (r_j <= r_n))
        else $error("scan ran past the window");
`endif
endmodule

[rtl/core/window_entropy_anomaly_detector.sv]
// Window entropy anomaly detector: top level joining front, command queue and back.
// Depends on wead_pkg, wead_if, wead_fifo, wead_front, wead_back.
//
// Channels: i_flow carries one flow record per beat (valid/ready); o_result
// carries one result beat per window end; i_cfg writes the score threshold
// (always ready). A record with last_in_window set closes the window.
// Records are taken one per cycle while a window fills. After the closing
// beat, i_flow.ready stays low while the back end scans the flow store:
// for each of the five features and each of the N kept flows, a pass over
// the single store read port, plus a log2 per distinct value, plus per
// feature bookkeeping and, given two or more distinct values, the
// distinct-count log2 and the 20-step divider. The result waits in an
// output register, and i_flow reopens once it is loaded, so a stalled
// receiver only blocks the next window end. Reset clears counters, the
// queue and the result valid flag and sets the threshold to one half;
// the store contents need no clearing.
module window_entropy_anomaly_detector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wead_flow_if.sink      i_flow,
    wead_result_if.source  o_result,
    wead_cfg_if.sink       i_cfg
);
    wead_pkg::t_store_wr wr;
    wead_pkg::t_win_cmd  cmd_in, cmd_out;
    logic                cmd_push, cmd_pop, cmd_valid, cmd_full;
    logic                release_store;

    wead_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (i_flow),
        .i_release  (release_store),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .o_wr       (wr)
    );

    wead_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_full  (cmd_full),
        .o_data  (cmd_out)
    );

    wead_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_release   (release_store),
        .i_cfg       (i_cfg),
        .o_result    (o_result)
    );
endmodule

[dv/wead_tb_if.sv]
// Testbench control interface: the flag that switches off idling near the end.
// Depends on nothing; the block's own interfaces are used for the connections.
`timescale 1ns / 1ps

interface wead_tb_ctl_if;
    logic quiet;
endinterface

[dv/testbench.sv]
// Testbench for window_entropy_anomaly_detector: random flow windows against an
// in-bench entropy predictor, with threshold writes between phases.
// Depends on wead_pkg, wead_if, wead_tb_if and the detector RTL.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        label;
        logic        present;
        logic        last;
    } t_flow_rec;

    typedef struct packed {
        logic [16:0] ent_src_addr;
        logic [16:0] ent_dst_addr;
        logic [16:0] ent_src_port;
        logic [16:0] ent_dst_port;
        logic [16:0] ent_tuple;
        logic [16:0] anomaly_score;
        logic        attack_predicted;
        logic        majority_attack;
        logic [10:0] valid_flows;
    } t_window_result;

    class t_window_scoreboard;
        bit [31:0]      src_q[$];
        bit [31:0]      dst_q[$];
        bit [15:0]      sport_q[$];
        bit [15:0]      dport_q[$];
        int unsigned    attacks;
        bit [16:0]      threshold;
        t_window_result pending[$];
        int             errors;
        int             windows;
        int             checked;

        function new();
            threshold = wead_pkg::THRESHOLD_INIT;
        endfunction

        function longint unsigned log2_q24(int unsigned x);
            int unsigned     k;
            int unsigned     t;
            longint unsigned m;
            longint unsigned r;
            k = 0;
            t = x;
            if (x == 0) return 0;
            while (t > 1) begin
                t >>= 1;
                k++;
            end
            m = longint'(x) << (31 - k);
            r = longint'(k) << wead_pkg::FRAC_BITS;
            for (int i = wead_pkg::FRAC_BITS - 1; i >= 0; i--) begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000) begin
                    r |= 64'd1 << i;
                    m >>= 1;
                end
            end
            return r;
        endfunction

        function bit [16:0] feature_entropy(wead_pkg::t_feature f);
            int unsigned     runs[bit [95:0]];
            bit [95:0]       key;
            longint unsigned s;
            longint unsigned total;
            longint unsigned num;
            longint unsigned den;
            longint unsigned e;
            int unsigned     n;
            n = src_q.size();
            s = 0;
            for (int k = 0; k < n; k++) begin
                case (f)
                    wead_pkg::FEAT_SRC_ADDR: key = src_q[k];
                    wead_pkg::FEAT_DST_ADDR: key = dst_q[k];
                    wead_pkg::FEAT_SRC_PORT: key = sport_q[k];
                    wead_pkg::FEAT_DST_PORT: key = dport_q[k];
                    default: key = {src_q[k], dst_q[k], sport_q[k], dport_q[k]};
                endcase
                if (runs.exists(key)) runs[key]++;
                else runs[key] = 1;
            end
            if (runs.num() < 2) return 0;
            foreach (runs[kv]) s += longint'(runs[kv]) * log2_q24(runs[kv]);
            total = longint'(n) * log2_q24(n);
            num = total > s ? total - s : 0;
            den = longint'(n) * log2_q24(runs.num());
            e = (num << 16) / den;
            return e > 65536 ? 17'd65536 : 17'(e);
        endfunction

        function void note_flow(t_flow_rec r);
            t_window_result res;
            int unsigned    deficit;
            bit [16:0]      e;
            int unsigned    n;
            if (r.present && src_q.size() < wead_pkg::WINDOW_DEPTH) begin
                src_q.push_back(r.src);
                dst_q.push_back(r.dst);
                sport_q.push_back(r.sport);
                dport_q.push_back(r.dport);
                attacks += r.label;
            end
            if (!r.last) return;
            res = '0;
            n = src_q.size();
            if (n > 0) begin
                deficit = 0;
                for (int f = 0; f < wead_pkg::FEATURES; f++) begin
                    e = feature_entropy(wead_pkg::t_feature'(f));
                    deficit += 65536 - e;
                    case (wead_pkg::t_feature'(f))
                        wead_pkg::FEAT_SRC_ADDR: res.ent_src_addr = e;
                        wead_pkg::FEAT_DST_ADDR: res.ent_dst_addr = e;
                        wead_pkg::FEAT_SRC_PORT: res.ent_src_port = e;
                        wead_pkg::FEAT_DST_PORT: res.ent_dst_port = e;
                        default:                 res.ent_tuple    = e;
                    endcase
                end
                res.anomaly_score    = 17'(deficit / wead_pkg::FEATURES);
                res.attack_predicted = res.anomaly_score > threshold;
                res.majority_attack  = attacks > n / 2;
                res.valid_flows      = 11'(n);
            end
            pending.push_back(res);
            windows++;
            src_q.delete();
            dst_q.delete();
            sport_q.delete();
            dport_q.delete();
            attacks = 0;
        endfunction

        function void field_check(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(t_window_result got);
            t_window_result exp;
            if (pending.size() == 0) begin
                $error("result beat with no window pending");
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            field_check("ent_src_addr", exp.ent_src_addr, got.ent_src_addr);
            field_check("ent_dst_addr", exp.ent_dst_addr, got.ent_dst_addr);
            field_check("ent_src_port", exp.ent_src_port, got.ent_src_port);
            field_check("ent_dst_port", exp.ent_dst_port, got.ent_dst_port);
            field_check("ent_tuple", exp.ent_tuple, got.ent_tuple);
            field_check("anomaly_score", exp.anomaly_score, got.anomaly_score);
            field_check("attack_predicted", exp.attack_predicted, got.attack_predicted);
            field_check("majority_attack", exp.majority_attack, got.majority_attack);
            field_check("valid_flows", exp.valid_flows, got.valid_flows);
        endfunction
    endclass

    localparam longint CYCLE_LIMIT = 30_000_000;

    logic i_clk;
    logic i_rst_n;
    int   stall_left;
    int   flows_sent;
    longint cycles;
    t_window_scoreboard sb;

    wead_tb_ctl_if tb_ctl();
    wead_flow_if   flow_ch();
    wead_result_if result_ch();
    wead_cfg_if    cfg_ch();

    window_entropy_anomaly_detector i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (flow_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: stalls in bursts, none once quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else if (!tb_ctl.quiet && $urandom_range(0, 5) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // outputs are stable at the falling edge; a beat there lands on the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_result('{result_ch.ent_src_addr, result_ch.ent_dst_addr,
                              result_ch.ent_src_port, result_ch.ent_dst_port,
                              result_ch.ent_tuple, result_ch.anomaly_score,
                              result_ch.attack_predicted, result_ch.majority_attack,
                              result_ch.valid_flows});
    end

    task automatic send_flow(t_flow_rec r);
        if (!tb_ctl.quiet && $urandom_range(0, 7) == 0) begin
            flow_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        flow_ch.valid             <= 1'b1;
        flow_ch.src_addr          <= r.src;
        flow_ch.dst_addr          <= r.dst;
        flow_ch.src_port_in       <= r.sport;
        flow_ch.dst_port_in       <= r.dport;
        flow_ch.attack_label      <= r.label;
        flow_ch.addresses_present <= r.present;
        flow_ch.last_in_window    <= r.last;
        do @(negedge i_clk); while (!flow_ch.ready);
        sb.note_flow(r);
        flows_sent++;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        flow_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [16:0] value);
        wait_drained();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.score_threshold <= value;
        do @(negedge i_clk); while (!cfg_ch.ready);
        sb.threshold = value;
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one window; values drawn from small pools so counts repeat, or random when noise is set
    task automatic send_window(int n, int pool, bit noise);
        logic [31:0] src_pool[16];
        logic [31:0] dst_pool[16];
        logic [15:0] sp_pool[16];
        logic [15:0] dp_pool[16];
        t_flow_rec   r;
        for (int i = 0; i < 16; i++) begin
            src_pool[i] = $urandom;
            dst_pool[i] = $urandom;
            sp_pool[i]  = $urandom;
            dp_pool[i]  = $urandom;
        end
        for (int i = 0; i < n; i++) begin
            r.src     = noise ? $urandom : src_pool[$urandom_range(0, pool - 1)];
            r.dst     = noise ? $urandom : dst_pool[$urandom_range(0, pool - 1)];
            r.sport   = noise ? $urandom : sp_pool[$urandom_range(0, pool - 1)];
            r.dport   = noise ? $urandom : dp_pool[$urandom_range(0, pool - 1)];
            r.label   = $urandom_range(0, 1);
            // an overlong window keeps every record so the store really fills
            r.present = noise ? $urandom_range(0, 1)
                              : (n > wead_pkg::WINDOW_DEPTH || $urandom_range(0, 9) != 0);
            r.last    = (i == n - 1);
            send_flow(r);
        end
    endtask

    initial begin
        logic [16:0] settings[5];
        sb                  = new();
        tb_ctl.quiet        = 1'b0;
        cycles              = 0;
        flows_sent          = 0;
        i_rst_n             = 1'b0;
        flow_ch.valid       = 1'b0;
        flow_ch.src_addr    = '0;
        flow_ch.dst_addr    = '0;
        flow_ch.src_port_in = '0;
        flow_ch.dst_port_in = '0;
        flow_ch.attack_label      = 1'b0;
        flow_ch.addresses_present = 1'b0;
        flow_ch.last_in_window    = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.score_threshold = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset threshold
        send_flow('{'0, '0, '0, '0, 1'b0, 1'b0, 1'b1});                 // empty window
        send_flow('{'1, '1, '1, '1, 1'b1, 1'b1, 1'b1});                 // single flow
        send_flow('{'0, '0, '0, '0, 1'b1, 1'b1, 1'b0});                 // two extremes
        send_flow('{'1, '1, '1, '1, 1'b1, 1'b1, 1'b1});
        send_flow('{32'h0a000001, 32'h0a000002, 16'd80, 16'd443, 1'b0, 1'b1, 1'b0});
        send_flow('{32'h0a000003, 32'h0a000002, 16'd81, 16'd443, 1'b1, 1'b1, 1'b0});
        send_flow('{'1, '1, '1, '1, 1'b1, 1'b0, 1'b1});                 // absent closer
        for (int i = 0; i < 3; i++)                                     // one distinct value
            send_flow('{32'hc0a80001, 32'hc0a80002, 16'd53, 16'd53, 1'b1, 1'b1, i == 2});
        for (int i = 0; i < 4; i++)                                     // label tie
            send_flow('{32'h01020304, 32'(i), 16'(i / 2), 16'd8080, 1'(i[0]), 1'b1, i == 3});

        settings = '{17'd0, 17'd65536, 17'd131071, 17'($urandom_range(0, 65536)), 17'd32768};
        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(settings[ph]);
            if (ph == 4) tb_ctl.quiet = 1'b1;
            if (ph == 2) begin
                // overfull window with few distinct values
                send_window(wead_pkg::WINDOW_DEPTH + 6, 4, 1'b0);
            end
            while (flows_sent < 20 + (ph + 1) * 166 +
                                (ph >= 2 ? wead_pkg::WINDOW_DEPTH + 6 : 0)) begin
                case ($urandom_range(0, 19))
                    0:       send_window($urandom_range(1, 12), 16, 1'b1);
                    1:       send_window($urandom_range(30, 50), $urandom_range(1, 16), 1'b0);
                    default: send_window($urandom_range(1, 12), $urandom_range(1, 6), 1'b0);
                endcase
            end
        end

        flow_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d flow records in %0d windows, %0d results checked,",
                 flows_sent, sb.windows, sb.checked);
        $display("including an overfull window and thresholds 0, 1.0 and above 1.0.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
